/* hw/rtl/lsb_pkg.sv */
// Shared types and constants of the launcher sequencer with belt sync.
// Used by every module of the block.
package lsb_pkg;

  localparam int unsigned TICK_MS   = 10;   // length of one tick, ms
  localparam int unsigned FRAC_BITS = 16;   // Q16.16 fixed point
  localparam int unsigned GAIN_W    = 25;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned PROD_W    = GAIN_W + MAG_W;
  localparam int unsigned TRQ_W     = 44;   // room for set - speed - coupling term
  localparam int unsigned DLY_W     = 18;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SW_UNKNOWN = 2'd0,
    SW_UP      = 2'd1,
    SW_DOWN    = 2'd2,
    SW_MIDDLE  = 2'd3
  } sw_t;

  typedef enum logic [2:0] {
    ST_DISABLE   = 3'd0,
    ST_RESETTING = 3'd1,
    ST_INIT      = 3'd2,
    ST_LOADING   = 3'd3,
    ST_READY     = 3'd4,
    ST_CANCEL    = 3'd5
  } stage_t;

  typedef enum logic [2:0] {
    FL_INIT    = 3'd0,
    FL_LIFTING = 3'd1,
    FL_DOWNING = 3'd2,
    FL_FILLING = 3'd3,
    FL_READY   = 3'd4
  } fill_t;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_END_LAUNCH = 2'd1,
    ACT_SETTLED    = 2'd2,
    ACT_CLOSE      = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    LIFT_OFF  = 2'd0,
    LIFT_UP   = 2'd1,
    LIFT_DOWN = 2'd2
  } lift_t;

  typedef enum logic [2:0] {
    CFG_BELT_SPEED   = 3'd0,
    CFG_SYNC_GAIN    = 3'd1,
    CFG_TORQUE_LIMIT = 3'd2,
    CFG_FIRE_HOLD    = 3'd3,
    CFG_SETTLE       = 3'd4,
    CFG_FEED_OPEN    = 3'd5,
    CFG_STALL_LIMIT  = 3'd6,
    CFG_STALL_LEVEL  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [30:0] belt_speed;
    logic [24:0] sync_gain;
    logic [30:0] torque_limit;
    logic [15:0] fire_hold_ms;
    logic [15:0] settle_ms;
    logic [15:0] feed_open_ms;
    logic [15:0] stall_limit;
    logic [30:0] stall_level;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         left_switch;
    logic [1:0]         right_switch;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
  } item_t;

  // Item plus the state-independent part of the work, done one stage early
  typedef struct packed {
    item_t              item;
    logic [PROD_W-1:0]  prod;     // sync_gain * |left - right|
    logic               rel_neg;  // left speed below right speed
    logic               slow_l;   // |left speed| < stall_level
    logic               slow_r;
  } prod_t;

endpackage

/* hw/rtl/lsb_if.sv */
// Valid/ready channel interfaces of the launcher sequencer.
// Depends on lsb_pkg for nothing but keeps the same field widths.
interface lsb_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [1:0]         left_switch;
  logic [1:0]         right_switch;
  logic signed [31:0] left_speed;
  logic signed [31:0] right_speed;

  modport source (output valid, opcode, left_switch, right_switch, left_speed,
                  right_speed, input ready);
  modport sink (input valid, opcode, left_switch, right_switch, left_speed,
                right_speed, output ready);
endinterface

interface lsb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_torque;
  logic signed [31:0] right_torque;
  logic               trigger_locked;
  logic [1:0]         lift_command;
  logic               limiter_open;
  logic [2:0]         launch_stage;
  logic [2:0]         fill_stage;

  modport source (output valid, left_torque, right_torque, trigger_locked,
                  lift_command, limiter_open, launch_stage, fill_stage,
                  input ready);
  modport sink (input valid, left_torque, right_torque, trigger_locked,
                lift_command, limiter_open, launch_stage, fill_stage,
                output ready);
endinterface

/* hw/rtl/lsb_cfg.sv */
// Configuration register file of the launcher sequencer.
// Depends on lsb_pkg (cfg_t, register index codes).
module lsb_cfg
  import lsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [30:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.belt_speed   <= 31'd6553600;
      cfg_r.sync_gain    <= 25'd65536;
      cfg_r.torque_limit <= 31'd655360;
      cfg_r.fire_hold_ms <= 16'd500;
      cfg_r.settle_ms    <= 16'd500;
      cfg_r.feed_open_ms <= 16'd2000;
      cfg_r.stall_limit  <= 16'd1000;
      cfg_r.stall_level  <= 31'd32768;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BELT_SPEED:   cfg_r.belt_speed   <= cfg_data;
        CFG_SYNC_GAIN:    cfg_r.sync_gain    <= cfg_data[24:0];
        CFG_TORQUE_LIMIT: cfg_r.torque_limit <= cfg_data;
        CFG_FIRE_HOLD:    cfg_r.fire_hold_ms <= cfg_data[15:0];
        CFG_SETTLE:       cfg_r.settle_ms    <= cfg_data[15:0];
        CFG_FEED_OPEN:    cfg_r.feed_open_ms <= cfg_data[15:0];
        CFG_STALL_LIMIT:  cfg_r.stall_limit  <= cfg_data[15:0];
        CFG_STALL_LEVEL:  cfg_r.stall_level  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/lsb_front.sv */
// Input register and coupling multiply stage of the launcher sequencer.
// Depends on lsb_pkg (item_t, prod_t, cfg_t) and lsb_in_if.
module lsb_front
  import lsb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  lsb_in_if.sink in_ch,
  output prod_t p_q,
  output logic  p_valid,
  input  logic  p_ready
);

  logic               s1_v_r;
  item_t              s1_r;
  logic               s2_v_r;
  prod_t              s2_r;
  logic               s1_rdy;
  logic               s2_rdy;

  logic signed [32:0] rel;
  logic               rel_neg;
  logic [32:0]        rel_abs;
  logic [31:0]        vl_mag;
  logic [31:0]        vr_mag;
  logic [PROD_W-1:0]  prod_w;

  assign s2_rdy      = !s2_v_r || p_ready;
  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_ch.valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_ch.valid) begin
      s1_r.opcode       <= in_ch.opcode;
      s1_r.left_switch  <= in_ch.left_switch;
      s1_r.right_switch <= in_ch.right_switch;
      s1_r.left_speed   <= in_ch.left_speed;
      s1_r.right_speed  <= in_ch.right_speed;
    end
  end

  // The coupling term depends only on the speeds and the sync gain, so it is formed here
  assign rel     = $signed({s1_r.left_speed[31], s1_r.left_speed})
                 - $signed({s1_r.right_speed[31], s1_r.right_speed});
  assign rel_neg = rel[32];
  assign rel_abs = rel_neg ? 33'(-rel) : 33'(rel);
  assign prod_w  = PROD_W'(cfg.sync_gain) * PROD_W'(rel_abs[MAG_W-1:0]);

  assign vl_mag = s1_r.left_speed[31]  ? 32'(-s1_r.left_speed)  : s1_r.left_speed;
  assign vr_mag = s1_r.right_speed[31] ? 32'(-s1_r.right_speed) : s1_r.right_speed;

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_r.item    <= s1_r;
      s2_r.prod    <= prod_w;
      s2_r.rel_neg <= rel_neg;
      s2_r.slow_l  <= vl_mag < {1'b0, cfg.stall_level};
      s2_r.slow_r  <= vr_mag < {1'b0, cfg.stall_level};
    end
  end

  assign p_q     = s2_r;
  assign p_valid = s2_v_r;

endmodule

/* hw/rtl/lsb_ctrl.sv */
// Stage machine, delay timer and torque output stage of the launcher sequencer.
// Depends on lsb_pkg (state enums, prod_t, cfg_t) and lsb_out_if.
module lsb_ctrl
  import lsb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  prod_t p_q,
  input  logic  p_valid,
  output logic  p_ready,
  lsb_out_if.source out_ch
);

  // state registers double as the result register
  stage_t                  stage_r,  stage_nxt;
  fill_t                   fill_r,   fill_nxt;
  sw_t                     prev_rsw_r, prev_rsw_nxt;
  logic [15:0]             cnt_r,    cnt_nxt;
  logic                    lock_r,   lock_nxt;
  logic                    busy_r,   busy_nxt;
  logic signed [DLY_W-1:0] left_r,   left_nxt;
  act_t                    act_r,    act_nxt;
  logic                    trig_r,   trig_nxt;
  lift_t                   lift_r,   lift_nxt;
  logic                    lim_r,    lim_nxt;
  logic signed [31:0]      tl_r,     tl_nxt;
  logic signed [31:0]      tr_r,     tr_nxt;
  logic                    out_v_r;

  logic                    fire;
  logic                    l_down;
  logic                    r_down;
  logic                    stall_hit;
  logic [31:0]             tl_mag;
  logic [31:0]             tr_mag;

  logic [PROD_W:0]         rnd_sum;
  logic [TRQ_W-1:0]        m_ext;
  logic signed [TRQ_W-1:0] s_l;
  logic signed [TRQ_W-1:0] set_pos;
  logic signed [TRQ_W-1:0] vl_ext;
  logic signed [TRQ_W-1:0] vr_ext;
  logic signed [31:0]      tl_pos, tl_neg, tr_pos, tr_neg;

  function automatic logic signed [31:0] sat_trq(input logic signed [TRQ_W-1:0] t,
                                                 input logic [30:0] lim);
    logic signed [TRQ_W-1:0] hi;
    logic signed [TRQ_W-1:0] lo;
    hi = $signed({{(TRQ_W-31){1'b0}}, lim});
    lo = -hi;
    if (t > hi)      sat_trq = hi[31:0];
    else if (t < lo) sat_trq = lo[31:0];
    else             sat_trq = t[31:0];
  endfunction

  assign p_ready = !out_v_r || out_ch.ready;
  assign fire    = p_valid && p_ready;

  // coupling term: round half away from zero, then apply the sign
  assign rnd_sum = {1'b0, p_q.prod} + (PROD_W+1)'(1 << (FRAC_BITS - 1));
  assign m_ext   = TRQ_W'(rnd_sum[PROD_W:FRAC_BITS]);
  assign s_l     = p_q.rel_neg ? -$signed(m_ext) : $signed(m_ext);
  assign set_pos = $signed({{(TRQ_W-31){1'b0}}, cfg.belt_speed});
  assign vl_ext  = TRQ_W'(p_q.item.left_speed);
  assign vr_ext  = TRQ_W'(p_q.item.right_speed);

  assign tl_pos = sat_trq(set_pos - vl_ext - s_l, cfg.torque_limit);
  assign tl_neg = sat_trq(-set_pos - vl_ext - s_l, cfg.torque_limit);
  assign tr_pos = sat_trq(set_pos - vr_ext + s_l, cfg.torque_limit);
  assign tr_neg = sat_trq(-set_pos - vr_ext + s_l, cfg.torque_limit);

  assign tl_mag = tl_r[31] ? 32'(-tl_r) : tl_r;
  assign tr_mag = tr_r[31] ? 32'(-tr_r) : tr_r;

  assign l_down = (p_q.item.left_switch == SW_DOWN) || (p_q.item.left_switch == SW_UNKNOWN);
  assign r_down = (p_q.item.right_switch == SW_DOWN) || (p_q.item.right_switch == SW_UNKNOWN);
  assign stall_hit = (p_q.slow_l && (tl_mag > {1'b0, cfg.stall_level}))
                  || (p_q.slow_r && (tr_mag > {1'b0, cfg.stall_level}));

  // next state; assignments run in order, as the sequencer does its steps
  always_comb begin
    stage_nxt    = stage_r;
    fill_nxt     = fill_r;
    prev_rsw_nxt = prev_rsw_r;
    cnt_nxt      = cnt_r;
    lock_nxt     = lock_r;
    busy_nxt     = busy_r;
    left_nxt     = left_r;
    act_nxt      = act_r;
    trig_nxt     = trig_r;
    lift_nxt     = lift_r;
    lim_nxt      = lim_r;
    tl_nxt       = tl_r;
    tr_nxt       = tr_r;

    if (p_q.item.opcode == OP_TICK) begin
      if (busy_r && !left_r[DLY_W-1] && (left_r != '0)) begin
        left_nxt = left_r - DLY_W'(TICK_MS);
        if (left_nxt[DLY_W-1] || (left_nxt == '0)) begin
          busy_nxt = 1'b0;
          act_nxt  = ACT_NONE;
          case (act_r)
            ACT_END_LAUNCH: begin
              lock_nxt  = 1'b1;
              stage_nxt = ST_RESETTING;
              cnt_nxt   = '0;
            end
            ACT_SETTLED: begin
              stage_nxt = ST_RESETTING;
              lock_nxt  = 1'b1;
              cnt_nxt   = '0;
              lim_nxt   = 1'b1;
              fill_nxt  = FL_FILLING;
              busy_nxt  = 1'b1;
              left_nxt  = DLY_W'(cfg.feed_open_ms);
              act_nxt   = ACT_CLOSE;
            end
            ACT_CLOSE: begin
              lim_nxt  = 1'b0;
              fill_nxt = FL_READY;
            end
            default: ;
          endcase
        end
      end
    end else begin
      if (l_down && r_down) begin
        stage_nxt = ST_DISABLE;
        tl_nxt    = '0;
        tr_nxt    = '0;
        busy_nxt  = 1'b0;
        act_nxt   = ACT_NONE;
        lock_nxt  = 1'b0;
        cnt_nxt   = '0;
        lim_nxt   = 1'b0;
        trig_nxt  = 1'b1;
      end else if (p_q.item.left_switch == SW_MIDDLE) begin
        if (stage_nxt == ST_DISABLE) begin
          stage_nxt = ST_RESETTING;
          cnt_nxt   = '0;
          lift_nxt  = LIFT_UP;
          fill_nxt  = FL_LIFTING;
        end
        // right switch leaving middle
        if (prev_rsw_r == SW_MIDDLE && p_q.item.right_switch == SW_DOWN) begin
          if (stage_nxt == ST_INIT) begin
            stage_nxt = ST_LOADING;
            cnt_nxt   = '0;
          end else if (stage_nxt == ST_READY) begin
            lift_nxt  = LIFT_UP;
            fill_nxt  = FL_LIFTING;
            stage_nxt = ST_CANCEL;
            cnt_nxt   = '0;
          end
        end else if (prev_rsw_r == SW_MIDDLE && p_q.item.right_switch == SW_UP) begin
          if (stage_nxt == ST_READY) begin
            lock_nxt  = 1'b0;
            stage_nxt = ST_INIT;
            fill_nxt  = FL_INIT;
            lift_nxt  = LIFT_UP;
            if (!busy_nxt) begin
              busy_nxt = 1'b1;
              left_nxt = DLY_W'(cfg.fire_hold_ms);
              act_nxt  = ACT_END_LAUNCH;
            end
          end
        end
        if (stall_hit && (cnt_nxt != 16'hFFFF)) cnt_nxt = cnt_nxt + 16'd1;
        if (cnt_nxt > cfg.stall_limit) begin
          case (stage_nxt)
            ST_RESETTING: begin
              if (lock_nxt) begin
                stage_nxt = ST_READY;
                fill_nxt  = FL_READY;
              end else begin
                stage_nxt = ST_INIT;
                fill_nxt  = FL_INIT;
              end
              cnt_nxt = '0;
            end
            ST_LOADING: begin
              lift_nxt = LIFT_DOWN;
              fill_nxt = FL_DOWNING;
              cnt_nxt  = '0;
              if (!busy_nxt) begin
                busy_nxt = 1'b1;
                left_nxt = DLY_W'(cfg.settle_ms);
                act_nxt  = ACT_SETTLED;
              end
            end
            ST_CANCEL: begin
              stage_nxt = ST_RESETTING;
              lock_nxt  = 1'b0;
              cnt_nxt   = '0;
              fill_nxt  = FL_INIT;
            end
            default: ;
          endcase
        end
        // belts reverse while resetting, run forward while loading or cancelling
        if (cfg.belt_speed == '0) begin
          tl_nxt = '0;
          tr_nxt = '0;
        end else if (stage_nxt == ST_RESETTING) begin
          tl_nxt = tl_neg;
          tr_nxt = tr_neg;
        end else if (stage_nxt == ST_LOADING || stage_nxt == ST_CANCEL) begin
          tl_nxt = tl_pos;
          tr_nxt = tr_pos;
        end else begin
          tl_nxt = '0;
          tr_nxt = '0;
        end
        trig_nxt = lock_nxt;
      end
      prev_rsw_nxt = sw_t'(p_q.item.right_switch);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= ST_DISABLE;
      fill_r     <= FL_INIT;
      prev_rsw_r <= SW_UNKNOWN;
      cnt_r      <= '0;
      lock_r     <= 1'b0;
      busy_r     <= 1'b0;
      left_r     <= '0;
      act_r      <= ACT_NONE;
      trig_r     <= 1'b1;
      lift_r     <= LIFT_OFF;
      lim_r      <= 1'b0;
      tl_r       <= '0;
      tr_r       <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (p_ready) out_v_r <= p_valid;
      if (fire) begin
        stage_r    <= stage_nxt;
        fill_r     <= fill_nxt;
        prev_rsw_r <= prev_rsw_nxt;
        cnt_r      <= cnt_nxt;
        lock_r     <= lock_nxt;
        busy_r     <= busy_nxt;
        left_r     <= left_nxt;
        act_r      <= act_nxt;
        trig_r     <= trig_nxt;
        lift_r     <= lift_nxt;
        lim_r      <= lim_nxt;
        tl_r       <= tl_nxt;
        tr_r       <= tr_nxt;
      end
    end
  end

  // outputs
  always_comb begin
    out_ch.valid          = out_v_r;
    out_ch.left_torque    = tl_r;
    out_ch.right_torque   = tr_r;
    out_ch.trigger_locked = trig_r;
    out_ch.lift_command   = lift_r;
    out_ch.limiter_open   = lim_r;
    out_ch.launch_stage   = stage_r;
    out_ch.fill_stage     = fill_r;
  end

`ifndef SYNTHESIS
  a_busy_has_action: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (act_r != ACT_NONE))
    else $error("delay pending flag and pending action disagree");

  a_disable_no_torque: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ST_DISABLE) |-> (tl_r == '0 && tr_r == '0))
    else $error("belt torque commanded while disabled");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> ($stable(stage_r) && $stable(tl_r) &&
                                    $stable(tr_r) && $stable(fill_r)))
    else $error("result changed while waiting for transfer");
`endif

endmodule

/* hw/rtl/launcher_sequencer_belt_sync_core.sv */
// Launcher sequencer with belt synchronization: top level.
// Depends on lsb_pkg, lsb_if, lsb_cfg, lsb_front and lsb_ctrl.
//
// Usage:
//   in_ch carries one item per transfer: a control update (opcode 0: both
//   switch positions and both belt speeds) or a timer tick (opcode 1).
//   out_ch returns exactly one result per item: the two belt torques and
//   the trigger, lift, limiter, launch stage and fill stage outputs.
//   cfg_we/cfg_idx/cfg_data write one configuration register per cycle;
//   write them only while no item is in flight.
// Timing:
//   An accepted item passes through stage one, which holds the input, and
//   stage two, which holds the coupling product; the stage machine then
//   updates the result register. Throughput is one item per cycle while
//   out_ch does not stall.
//   When out_ch stalls, the held result keeps its value and items queue in
//   the two front stages; in_ch.ready drops only once both are full.
// Reset:
//   rst_n (synchronous) empties the pipeline, puts the configuration at its
//   defaults and the sequencer in the disabled stage with zero torques.
module launcher_sequencer_belt_sync_core
  import lsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [30:0] cfg_data,
  lsb_in_if.sink      in_ch,
  lsb_out_if.source   out_ch
);

  cfg_t  cfg;
  prod_t p_q;
  logic  p_valid;
  logic  p_ready;

  lsb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  lsb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .p_q     (p_q),
    .p_valid (p_valid),
    .p_ready (p_ready)
  );

  lsb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .p_q     (p_q),
    .p_valid (p_valid),
    .p_ready (p_ready),
    .out_ch  (out_ch)
  );

endmodule
